// File: rtl/wtn_pkg.sv
// wave table nco: shared constants, codes and a helper function
// no dependencies; imported by the channel interfaces, the top level and the testbench
package wtn_pkg;

  localparam int TABLE_DEPTH  = 4096;
  localparam int FRAC_BITS    = 12;
  localparam int SAMPLE_WIDTH = 16;

  localparam int INDEX_W  = $clog2(TABLE_DEPTH);
  localparam int PHASE_W  = INDEX_W + FRAC_BITS;
  localparam int TSIZE_W  = $clog2(TABLE_DEPTH) + 1;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PHASE_W;

  localparam logic [PHASE_W-1:0] STRIDE_RESET = PHASE_W'(1 << FRAC_BITS);
  localparam logic [TSIZE_W-1:0] TSIZE_RESET  = TSIZE_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_LOAD_RANGE   = 2'd1,
    ST_STRIDE_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE     = 1'b0,
    REG_TABLE_SIZE = 1'b1
  } reg_idx_t;

  // largest legal phase: (clamped size - 1) with the fraction bits appended
  function automatic logic [PHASE_W-1:0] max_phase(input logic [TSIZE_W-1:0] tsize);
    logic [TSIZE_W-1:0] n;
    n = tsize;
    if (n < TSIZE_W'(2)) n = TSIZE_W'(2);
    if (n > TSIZE_W'(TABLE_DEPTH)) n = TSIZE_W'(TABLE_DEPTH);
    n = n - TSIZE_W'(1);
    return {n[INDEX_W-1:0], {FRAC_BITS{1'b0}}};
  endfunction

  localparam logic [PHASE_W-1:0] MAXP_RESET = {INDEX_W'(TABLE_DEPTH - 1), {FRAC_BITS{1'b0}}};

endpackage

// File: rtl/wtn_ifs.sv
// wave table nco: valid/ready channel interfaces (input word, result word, config write)
// depends on wtn_pkg
interface wtn_item_if import wtn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [INDEX_W-1:0]      entry_index;
  logic [SAMPLE_WIDTH-1:0] entry_value;
  logic [PHASE_W-1:0]      phase_value;

  modport source (output valid, opcode, entry_index, entry_value, phase_value, input ready);
  modport sink   (input valid, opcode, entry_index, entry_value, phase_value, output ready);
endinterface

interface wtn_result_if import wtn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic [INDEX_W-1:0]      table_index;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, sample, table_index, status, input ready);
  modport sink   (input valid, sample, table_index, status, output ready);
endinterface

interface wtn_cfg_if import wtn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/wave_table_nco_top.sv
// wave table nco: phase accumulator with a single-port-write wave table memory
// path: a word accepted goes through the synchronous table read in the read stage
// and then through the output register
// throughput one word per cycle sustained while the result side is ready
// sync reset clears phase, stride (4096), max phase (table size 4096) and pipeline valids;
// the wave table is not cleared and holds undefined data until written
module wave_table_nco_top import wtn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wtn_cfg_if.sink     cfg,
  wtn_item_if.sink    item,
  wtn_result_if.source result
);

  // config registers; table_size is kept only as its precomputed max phase
  logic [PHASE_W-1:0] stride;
  logic [PHASE_W-1:0] maxp;

  // accumulator state
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  // wave table memory and its registered read port
  logic [SAMPLE_WIDTH-1:0] wave_mem [TABLE_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data;

  // read stage (word waiting for its table read)
  logic                s1_valid;
  logic                s1_use_sample;
  logic [INDEX_W-1:0]  s1_index;
  status_t             s1_status;
  logic                s1_move;

  // step decode
  logic               accept;
  op_t                op;
  logic [PHASE_W:0]   sum;
  logic [PHASE_W:0]   wrapped;
  logic [PHASE_W-1:0] phase_tick;
  logic               stride_bad;
  logic               load_bad;
  logic               use_sample;
  status_t            status_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= STRIDE_RESET;
      maxp   <= MAXP_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_STRIDE:     stride <= cfg.data;
        REG_TABLE_SIZE: begin
          maxp <= max_phase(cfg.data[TSIZE_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // a word enters whenever the read stage is empty or drains this cycle
  assign s1_move    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_move;
  assign accept     = item.valid && item.ready;
  assign op         = op_t'(item.opcode);

  // tick: add stride, fold back once when past the max phase
  assign sum        = {1'b0, phase} + {1'b0, stride};
  assign wrapped    = sum - {1'b0, maxp};
  assign phase_tick = (sum > {1'b0, maxp}) ? wrapped[PHASE_W-1:0] : sum[PHASE_W-1:0];
  assign stride_bad = stride >= maxp;
  assign load_bad   = item.phase_value >= maxp;

  always_comb begin
    phase_next  = phase;
    use_sample  = 1'b0;
    status_next = ST_OK;
    case (op)
      OP_TICK: begin
        if (stride_bad) begin
          status_next = ST_STRIDE_RANGE;
        end else begin
          phase_next = phase_tick;
          use_sample = 1'b1;
        end
      end
      OP_LOAD: begin
        if (load_bad) begin
          status_next = ST_LOAD_RANGE;
        end else begin
          phase_next = item.phase_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // table write and read never share a word, so no bypass is needed;
  // a write accepted before a read of the same entry lands first
  always_ff @(posedge clk) begin
    if (accept && op == OP_WRITE) begin
      wave_mem[item.entry_index] <= item.entry_value;
    end
    if (accept && use_sample) begin
      rd_data <= wave_mem[phase_next[PHASE_W-1 -: INDEX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_use_sample <= use_sample;
      s1_index      <= phase_next[PHASE_W-1 -: INDEX_W];
      s1_status     <= status_next;
    end
  end

  // output register parts the memory stage from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (s1_move) begin
      result.sample      <= s1_use_sample ? rd_data : '0;
      result.table_index <= s1_index;
      result.status      <= s1_status;
    end
  end

  // a rejected word never carries a sample
  a_bad_no_sample: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |-> result.sample == '0)
    else $error("nonzero sample with error status");

  // a rejected phase load leaves the accumulator untouched
  a_load_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_LOAD && load_bad |=> phase == $past(phase))
    else $error("rejected phase load changed phase");

  // the read stage takes a word while holding one only if that one drains in the same cycle
  a_s1_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> s1_move)
    else $error("read stage overrun");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

// File: verif/wave_table_nco_top_tb.sv
// wave table nco testbench: directed and random words checked against an in-bench oscillator
// depends on wtn_pkg, the channel interfaces in wtn_ifs.sv and wave_table_nco_top
module wave_table_nco_top_tb;
  import wtn_pkg::*;

  localparam int LATENCY       = 2;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 850;
  localparam int RANDOM_PHASES = 8;

  // one result word as the oscillator should report it
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [INDEX_W-1:0]      table_index;
    status_t                 status;
  } nco_out_t;

  logic clk;
  logic rst;

  wtn_cfg_if    cfg_ch ();
  wtn_item_if   item_ch ();
  wtn_result_if result_ch ();

  wave_table_nco_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  // oscillator mirror: phase, registers and the wave table as far as it was written
  logic [PHASE_W-1:0]      osc_phase  = '0;
  logic [PHASE_W-1:0]      osc_stride = STRIDE_RESET;
  logic [TSIZE_W-1:0]      osc_tsize  = TSIZE_RESET;
  logic [SAMPLE_WIDTH-1:0] wave_mirror [TABLE_DEPTH];
  bit                      wave_written [TABLE_DEPTH];

  // result words still owed by the block, oldest first
  nco_out_t outputs_due [$];

  int mismatches    = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;
  int burst_left    = 0;

  // 20 unit clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls: the pattern is redrawn at random, from the running stall count, among
  // always ready, coin flip, a fixed 4-of-7 duty cycle and mostly stalled
  initial begin : rx_stall
    int mode;
    int stall_count;
    mode = 0;
    stall_count = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall_count++;
      if (stall_count % 256 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(0, 1));
        2: result_ch.ready <= (stall_count % 7) < 4;
        default: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words still owed", $time, cycle_count,
               outputs_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // largest legal phase for a table size, with the size clamped to 2..TABLE_DEPTH
  function automatic logic [PHASE_W-1:0] phase_limit(input logic [TSIZE_W-1:0] tsize);
    logic [TSIZE_W-1:0] n;
    n = tsize;
    if (n < TSIZE_W'(2)) n = TSIZE_W'(2);
    else if (n > TSIZE_W'(TABLE_DEPTH)) n = TSIZE_W'(TABLE_DEPTH);
    return {INDEX_W'(n - TSIZE_W'(1)), {FRAC_BITS{1'b0}}};
  endfunction

  // phase a tick would leave behind; unchanged when the stride is out of range
  function automatic logic [PHASE_W-1:0] phase_after_tick();
    logic [PHASE_W:0]   sum;
    logic [PHASE_W-1:0] lim;
    lim = phase_limit(osc_tsize);
    if (osc_stride >= lim) return osc_phase;
    sum = {1'b0, osc_phase} + {1'b0, osc_stride};
    // a single subtraction, even when a shrunken table left the phase far above the limit
    if (sum > {1'b0, lim}) sum = sum - {1'b0, lim};
    return sum[PHASE_W-1:0];
  endfunction

  // advance the mirror by one accepted word and return the result word it causes
  function automatic nco_out_t step_oscillator(input op_t op, input logic [INDEX_W-1:0] addr,
                                               input logic [SAMPLE_WIDTH-1:0] word,
                                               input logic [PHASE_W-1:0] new_phase);
    nco_out_t r;
    r.sample = '0;
    r.status = ST_OK;
    case (op)
      OP_TICK: begin
        if (osc_stride >= phase_limit(osc_tsize)) begin
          r.status = ST_STRIDE_RANGE;
        end else begin
          osc_phase = phase_after_tick();
          r.sample  = wave_mirror[osc_phase[PHASE_W-1:FRAC_BITS]];
        end
      end
      OP_WRITE: begin
        wave_mirror[addr]  = word;
        wave_written[addr] = 1'b1;
      end
      OP_LOAD: begin
        if (new_phase >= phase_limit(osc_tsize)) r.status = ST_LOAD_RANGE;
        else osc_phase = new_phase;
      end
      default: ;
    endcase
    r.table_index = osc_phase[PHASE_W-1:FRAC_BITS];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker: valid and ready are stable at the falling edge, so a word seen
  // here is the one taken at the next rising edge
  always @(negedge clk) begin : check_outputs
    nco_out_t due;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got sample %0h index %0h status %0d",
                 $time, result_ch.sample, result_ch.table_index, result_ch.status);
        mismatches++;
      end else begin
        due = outputs_due.pop_front();
        compare_field("sample", 32'(due.sample), 32'(result_ch.sample));
        compare_field("table_index", 32'(due.table_index), 32'(result_ch.table_index));
        compare_field("status", 32'(due.status), 32'(result_ch.status));
        words_checked++;
      end
    end
  end

  // send one input word; bursts of random length with random gaps between them
  task automatic issue_word(input op_t op, input logic [INDEX_W-1:0] addr,
                            input logic [SAMPLE_WIDTH-1:0] word,
                            input logic [PHASE_W-1:0] new_phase);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid       <= 1'b1;
    item_ch.opcode      <= op;
    item_ch.entry_index <= addr;
    item_ch.entry_value <= word;
    item_ch.phase_value <= new_phase;
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
    words_sent++;
    outputs_due.push_back(step_oscillator(op, addr, word, new_phase));
  endtask

  // tick, preceded by a table write whenever the tick would land on a word never written
  task automatic issue_tick();
    logic [PHASE_W-1:0] next_phase;
    next_phase = phase_after_tick();
    if (osc_stride < phase_limit(osc_tsize) && !wave_written[next_phase[PHASE_W-1:FRAC_BITS]])
      issue_word(OP_WRITE, next_phase[PHASE_W-1:FRAC_BITS], SAMPLE_WIDTH'($urandom),
                 PHASE_W'($urandom));
    issue_word(OP_TICK, INDEX_W'($urandom), SAMPLE_WIDTH'($urandom), PHASE_W'($urandom));
  endtask

  // stop sending and let every owed result word arrive, plus the pipeline depth
  task automatic drain_outputs();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input reg_idx_t r, input logic [CFG_DATA_W-1:0] d);
    drain_outputs();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    if (r == REG_STRIDE) osc_stride = d[PHASE_W-1:0];
    else osc_tsize = d[TSIZE_W-1:0];
  endtask

  // every opcode under the reset registers: sample extremes, wrap, landing on
  // the limit exactly, rejected phase loads
  task automatic test_ops_at_reset();
    issue_word(OP_WRITE, 12'd0, 16'hAAAA, 24'h000000);
    issue_word(OP_WRITE, 12'd1, 16'hFFFF, 24'hFFFFFF);
    issue_word(OP_WRITE, 12'd2, 16'h0000, 24'h555555);
    issue_word(OP_WRITE, 12'd3, 16'h5555, 24'hAAAAAA);
    issue_word(OP_WRITE, 12'hFFF, 16'h8001, 24'h000000);
    repeat (3) issue_tick();
    // unused opcode only reports the current index
    issue_word(OP_NONE, 12'hFFF, 16'hFFFF, 24'hFFFFFF);
    // just under the limit: the tick wraps around to index 0
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'hFFEFFF);
    issue_tick();
    // sum equal to the limit stays there, index 4095
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'hFFE000);
    issue_tick();
    // at and above the limit: rejected; a final load of 0 is accepted
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'hFFF000);
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'hFFFFFF);
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'h000000);
  endtask

  // stride and table size at their extremes, clamped sizes and a phase left
  // high by a smaller table
  task automatic test_register_limits();
    write_reg(REG_STRIDE, 24'h000000);
    issue_tick();
    write_reg(REG_STRIDE, 24'hFFFFFF);
    issue_tick();
    // stride equal to the limit is out of range too
    write_reg(REG_STRIDE, 24'hFFF000);
    issue_tick();
    write_reg(REG_STRIDE, 24'hFFEFFF);
    issue_tick();
    // size 0 acts as 2; the phase from above sits far over the new limit
    write_reg(REG_TABLE_SIZE, CFG_DATA_W'(0));
    write_reg(REG_STRIDE, 24'h000FFF);
    issue_tick();
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'h001000);
    issue_word(OP_LOAD, 12'd0, 16'd0, 24'h000FFF);
    issue_tick();
    // size 1 acts as 2 as well
    write_reg(REG_TABLE_SIZE, CFG_DATA_W'(1));
    write_reg(REG_STRIDE, 24'h001000);
    issue_tick();
    // oversize table acts as the full depth
    write_reg(REG_TABLE_SIZE, CFG_DATA_W'(13'h1FFF));
    write_reg(REG_STRIDE, 24'hFFEFFF);
    issue_tick();
  endtask

  // one random register setting, then mostly ticks mixed with writes, loads and no-ops
  task automatic test_random_phase(input int n_words);
    logic [TSIZE_W-1:0] tsize;
    logic [PHASE_W-1:0] lim;
    logic [PHASE_W-1:0] stride;
    int                 used;
    int                 start;
    int                 pick;
    case ($urandom_range(0, 9))
      0: tsize = TSIZE_W'(2);
      1: tsize = TSIZE_W'(3);
      2, 3, 4: tsize = TSIZE_W'($urandom_range(2, 32));
      5: tsize = TSIZE_W'($urandom_range(2, TABLE_DEPTH));
      6: tsize = TSIZE_W'(TABLE_DEPTH);
      7: tsize = TSIZE_W'($urandom_range(0, 1));
      8: tsize = TSIZE_W'($urandom_range(TABLE_DEPTH + 1, 8191));
      default: tsize = TSIZE_W'($urandom_range(33, 300));
    endcase
    lim = phase_limit(tsize);
    case ($urandom_range(0, 7))
      5: stride = lim - PHASE_W'(1);
      6: stride = PHASE_W'($urandom_range(lim, 24'hFFFFFF));
      7: stride = PHASE_W'($urandom_range(0, 4095));
      default: stride = PHASE_W'($urandom_range(0, lim - 1));
    endcase
    // bits above the size field are don't-care
    write_reg(REG_TABLE_SIZE, {(CFG_DATA_W - TSIZE_W)'($urandom), tsize});
    write_reg(REG_STRIDE, stride);
    used  = int'(lim >> FRAC_BITS) + 1;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        issue_tick();
      end else if (pick < 82) begin
        issue_word(OP_WRITE, ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom)
                                                           : INDEX_W'($urandom_range(0, used - 1)),
                   SAMPLE_WIDTH'($urandom), PHASE_W'($urandom));
      end else if (pick < 94) begin
        issue_word(OP_LOAD, INDEX_W'($urandom), SAMPLE_WIDTH'($urandom),
                   ($urandom_range(0, 3) == 0) ? PHASE_W'($urandom)
                                               : PHASE_W'($urandom_range(0, lim - 1)));
      end else begin
        issue_word(OP_NONE, INDEX_W'($urandom), SAMPLE_WIDTH'($urandom), PHASE_W'($urandom));
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) test_random_phase(RANDOM_WORDS / RANDOM_PHASES);
  endtask

  initial begin : stimulus
    // known values on every input from time zero
    rst                 <= 1'b1;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_STRIDE;
    cfg_ch.data         <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.opcode      <= OP_TICK;
    item_ch.entry_index <= '0;
    item_ch.entry_value <= '0;
    item_ch.phase_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_ops_at_reset();
    test_register_limits();
    test_random();
    drain_outputs();

    $display("covered %0d input words and %0d result words over %0d register writes,",
             words_sent, words_checked, reg_writes);
    $display("with wrap, clamped table sizes, rejected loads and out-of-range strides");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
